/* src/t3n_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package t3n_pkg;

   localparam int IDW   = 12;          // node number
   localparam int NW    = 13;          // node count, internal neighbor values
   localparam int SW    = 5;           // side and in-cube coordinates
   localparam int SSW   = 2 * SW;      // side squared
   localparam int RW    = 19;          // reciprocal of the side
   localparam int RSH   = 18;          // reciprocal scale, 2^RSH
   localparam int STW   = 2;           // status
   localparam int NB    = 6;           // neighbor slots
   localparam int SELW  = $clog2(NB);
   localparam int CIW   = 2;           // csr index
   localparam int CDW   = NW;          // csr data
   localparam int PID_W = IDW + RW;
   localparam int PM_W  = NW + RW;
   localparam int QS_W  = IDW + SW;
   localparam int XS_W  = IDW + SSW;
   localparam int PX_W  = SW + SSW;

   localparam logic [STW-1:0] ST_NEIGHBOR = 2'd0;
   localparam logic [STW-1:0] ST_NONE     = 2'd1;
   localparam logic [STW-1:0] ST_BAD      = 2'd2;

   localparam logic [CIW-1:0] CSR_NODE_COUNT  = 2'd0;
   localparam logic [CIW-1:0] CSR_SIDE_LENGTH = 2'd1;

   // ceil(2^18 / s), exact floor division for dividends below 2^13
   localparam logic [RW-1:0] RECIP_TABLE [32] = '{
      19'd262144, 19'd262144, 19'd131072, 19'd87382, 19'd65536, 19'd52429,
      19'd43691,  19'd37450,  19'd32768,  19'd29128, 19'd26215, 19'd23832,
      19'd21846,  19'd20165,  19'd18725,  19'd17477, 19'd16384, 19'd15421,
      19'd14564,  19'd13798,  19'd13108,  19'd12484, 19'd11916, 19'd11398,
      19'd10923,  19'd10486,  19'd10083,  19'd9710,  19'd9363,  19'd9040,
      19'd8739,   19'd8457
   };

   typedef struct packed {
      logic [NW-1:0]  n;
      logic [SW-1:0]  s;
      logic [SSW-1:0] ss;
      logic [RW-1:0]  recip;
   } cfg_type;

   typedef struct packed {
      logic           bad;
      logic [IDW-1:0] id;
      logic [NW-1:0]  m;      // node_count - 1 - id
      logic [NW-1:0]  mqy;    // m / s
      logic [NW-1:0]  mqx;    // m / s^2
      logic [IDW-1:0] x;
      logic [SW-1:0]  y;
      logic [SW-1:0]  z;
      logic [SSW-1:0] ry;     // id mod s^2
   } coord_type;

   typedef struct packed {
      logic                   bad;
      logic [NB-1:0]          keep;
      logic [NB-1:0][NW-1:0]  cand;
   } cand_type;

endpackage

`default_nettype wire

/* src/t3n_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface t3n_req_if;
   import t3n_pkg::*;
   logic           valid;
   logic           ready;
   logic [IDW-1:0] node_id;
   modport source (output valid, output node_id, input ready);
   modport sink (input valid, input node_id, output ready);
endinterface

`default_nettype wire

/* src/t3n_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface t3n_rsp_if;
   import t3n_pkg::*;
   logic           valid;
   logic           ready;
   logic [IDW-1:0] neighbor_id;
   logic [STW-1:0] status;
   logic           last;
   modport source (output valid, output neighbor_id, output status, output last,
                   input ready);
   modport sink (input valid, input neighbor_id, input status, input last,
                 output ready);
endinterface

`default_nettype wire

/* src/t3n_csr_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface t3n_csr_if;
   import t3n_pkg::*;
   logic           valid;
   logic           ready;
   logic [CIW-1:0] index;
   logic [CDW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/torus3d_neighbor_list.sv */
`timescale 1ns / 1ps
`default_nettype none

// a node beat passes through 7 pipeline stages and then the result register
// throughput: a node has 1 to 6 result beats, which the result register sends
// one per cycle while out_ready is high; a new node is taken only with the last
// beat of the one before, or when the result register is empty
// reset: clears all pipeline valid bits, node_count reads 1 and side_length 1

module torus3d_neighbor_list #(
   parameter int MAX_NODES = 4096,
   parameter int MAX_SIDE  = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   t3n_req_if.sink     req_bus,
   t3n_rsp_if.source   rsp_bus,
   t3n_csr_if.sink     csr_bus
);
   import t3n_pkg::*;

   cfg_type   cfg;
   logic      crd_valid, crd_ready;
   coord_type crd_data;
   logic      nbr_valid, nbr_ready;
   cand_type  nbr_data;

   t3n_csr #(
      .MAX_NODES (MAX_NODES),
      .MAX_SIDE  (MAX_SIDE)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   t3n_coord u_coord (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_id     (req_bus.node_id),
      .out_valid (crd_valid),
      .out_ready (crd_ready),
      .out_data  (crd_data)
   );

   t3n_nbr u_nbr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (crd_valid),
      .in_ready  (crd_ready),
      .in_data   (crd_data),
      .out_valid (nbr_valid),
      .out_ready (nbr_ready),
      .out_data  (nbr_data)
   );

   t3n_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (nbr_valid),
      .in_ready        (nbr_ready),
      .in_data         (nbr_data),
      .out_valid       (rsp_bus.valid),
      .out_ready       (rsp_bus.ready),
      .out_neighbor_id (rsp_bus.neighbor_id),
      .out_status      (rsp_bus.status),
      .out_last        (rsp_bus.last)
   );

endmodule

`default_nettype wire

/* src/t3n_csr.sv */
`timescale 1ns / 1ps
`default_nettype none

module t3n_csr #(
   parameter int MAX_NODES = 4096,
   parameter int MAX_SIDE  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   t3n_csr_if.sink               csr_bus,
   output t3n_pkg::cfg_type      cfg
);
   import t3n_pkg::*;

   localparam logic [NW-1:0] N_CLAMP = NW'(MAX_NODES);
   localparam logic [SW-1:0] S_CLAMP = SW'(MAX_SIDE);

   cfg_type        cfg_ff, cfg_in;
   logic [SW-1:0]  s_raw;
   logic [SW-1:0]  s_eff;
   logic [SSW-1:0] s_wide;

   assign csr_bus.ready = 1'b1;
   assign s_raw         = csr_bus.data[SW-1:0];

   always_comb begin
      if (s_raw == '0) begin
         s_eff = SW'(1);
      end else if (int'(s_raw) > MAX_SIDE) begin
         s_eff = S_CLAMP;
      end else begin
         s_eff = s_raw;
      end
   end

   assign s_wide = SSW'(s_eff);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_NODE_COUNT: begin
               cfg_in.n = (int'(csr_bus.data) > MAX_NODES) ? N_CLAMP : csr_bus.data;
            end
            CSR_SIDE_LENGTH: begin
               cfg_in.s     = s_eff;
               cfg_in.ss    = s_wide * s_wide;
               cfg_in.recip = RECIP_TABLE[s_eff];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.n     <= NW'(1);
         cfg_ff.s     <= SW'(1);
         cfg_ff.ss    <= SSW'(1);
         cfg_ff.recip <= RECIP_TABLE[1];
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* src/t3n_coord.sv */
`timescale 1ns / 1ps
`default_nettype none

// splits the node number into x, y, z by reciprocal multiplication, four stages
module t3n_coord (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire t3n_pkg::cfg_type       cfg,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic [t3n_pkg::IDW-1:0] in_id,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output t3n_pkg::coord_type          out_data
);
   import t3n_pkg::*;

   typedef struct packed {
      logic           bad;
      logic [IDW-1:0] id;
      logic [NW-1:0]  m;
   } st1_type;

   typedef struct packed {
      logic           bad;
      logic [IDW-1:0] id;
      logic [NW-1:0]  m;
      logic [IDW-1:0] q1;
      logic [NW-1:0]  mqy;
   } st2_type;

   typedef struct packed {
      logic           bad;
      logic [IDW-1:0] id;
      logic [NW-1:0]  m;
      logic [IDW-1:0] q1;
      logic [NW-1:0]  mqy;
      logic [NW-1:0]  mqx;
      logic [IDW-1:0] x;
      logic [SW-1:0]  z;
   } st3_type;

   logic      s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic      s1_ready, s2_ready, s3_ready, s4_ready;
   st1_type   s1_ff, s1_in;
   st2_type   s2_ff, s2_in;
   st3_type   s3_ff, s3_in;
   coord_type s4_ff, s4_in;

   logic [PID_W-1:0] p_id;
   logic [PM_W-1:0]  p_m;
   logic [PID_W-1:0] p_q1;
   logic [PM_W-1:0]  p_mqy;
   logic [QS_W-1:0]  q1_s;
   logic [QS_W-1:0]  z_full;
   logic [QS_W-1:0]  x_s;
   logic [QS_W-1:0]  y_full;
   logic [XS_W-1:0]  x_ss;
   logic [XS_W-1:0]  ry_full;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // stage 1: range check and headroom above the node
   always_comb begin
      s1_in.bad = NW'(in_id) >= cfg.n;
      s1_in.id  = in_id;
      s1_in.m   = cfg.n - NW'(1) - NW'(in_id);
   end

   // stage 2: first division by the side
   always_comb begin
      p_id      = PID_W'(s1_ff.id) * PID_W'(cfg.recip);
      p_m       = PM_W'(s1_ff.m) * PM_W'(cfg.recip);
      s2_in.bad = s1_ff.bad;
      s2_in.id  = s1_ff.id;
      s2_in.m   = s1_ff.m;
      s2_in.q1  = p_id[RSH +: IDW];
      s2_in.mqy = p_m[RSH +: NW];
   end

   // stage 3: z remainder and second division
   always_comb begin
      q1_s      = QS_W'(s2_ff.q1) * QS_W'(cfg.s);
      z_full    = QS_W'(s2_ff.id) - q1_s;
      p_q1      = PID_W'(s2_ff.q1) * PID_W'(cfg.recip);
      p_mqy     = PM_W'(s2_ff.mqy) * PM_W'(cfg.recip);
      s3_in.bad = s2_ff.bad;
      s3_in.id  = s2_ff.id;
      s3_in.m   = s2_ff.m;
      s3_in.q1  = s2_ff.q1;
      s3_in.mqy = s2_ff.mqy;
      s3_in.mqx = p_mqy[RSH +: NW];
      s3_in.x   = p_q1[RSH +: IDW];
      s3_in.z   = z_full[SW-1:0];
   end

   // stage 4: y and the offset inside the x plane
   always_comb begin
      x_s       = QS_W'(s3_ff.x) * QS_W'(cfg.s);
      y_full    = QS_W'(s3_ff.q1) - x_s;
      x_ss      = XS_W'(s3_ff.x) * XS_W'(cfg.ss);
      ry_full   = XS_W'(s3_ff.id) - x_ss;
      s4_in.bad = s3_ff.bad;
      s4_in.id  = s3_ff.id;
      s4_in.m   = s3_ff.m;
      s4_in.mqy = s3_ff.mqy;
      s4_in.mqx = s3_ff.mqx;
      s4_in.x   = s3_ff.x;
      s4_in.y   = y_full[SW-1:0];
      s4_in.z   = s3_ff.z;
      s4_in.ry  = ry_full[SSW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) s1_ff <= s1_in;
      if (s2_ready && s1_valid_ff) s2_ff <= s2_in;
      if (s3_ready && s2_valid_ff) s3_ff <= s3_in;
      if (s4_ready && s3_valid_ff) s4_ff <= s4_in;
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_ff;

endmodule

`default_nettype wire

/* src/t3n_nbr.sv */
`timescale 1ns / 1ps
`default_nettype none

// neighbor candidates in x-, y-, z-, x+, y+, z+ order, then duplicate removal
module t3n_nbr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire t3n_pkg::cfg_type   cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire t3n_pkg::coord_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output t3n_pkg::cand_type       out_data
);
   import t3n_pkg::*;

   localparam int XM = 0;
   localparam int YM = 1;
   localparam int ZM = 2;
   localparam int XP = 3;
   localparam int YP = 4;
   localparam int ZP = 5;

   typedef struct packed {
      logic           bad;
      logic [IDW-1:0] id;
      logic           x0, y0, z0;
      logic           xin;     // x inside the cube
      logic           xle;     // x - 1 inside the cube
      logic           fwd_x, fwd_y, fwd_z;
      logic           qpos_x, qpos_y, qpos_z;
      logic [PX_W-1:0] prod_x;
      logic [SSW-1:0] prod_y;
      logic [SW-1:0]  prod_z;
      logic [SSW-1:0] ry;
      logic [SW-1:0]  z;
   } st5_type;

   logic     s5_valid_ff, s6_valid_ff, s7_valid_ff;
   logic     s5_ready, s6_ready, s7_ready;
   st5_type  s5_ff, s5_in;
   cand_type s6_ff, s6_in;
   cand_type s7_ff, s7_in;

   logic [SW-1:0] sm1;
   logic [SW-1:0] qmax_x, qmax_y, qmax_z;
   logic [NW-1:0] idw;

   assign s7_ready = !s7_valid_ff || out_ready;
   assign s6_ready = !s6_valid_ff || s7_ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign in_ready = s5_ready;

   // stage 5: highest wrap target on each line, forward step checks
   always_comb begin
      sm1    = cfg.s - SW'(1);
      qmax_z = (in_data.m >= NW'(sm1)) ? sm1 : in_data.m[SW-1:0];
      qmax_y = (in_data.mqy >= NW'(sm1)) ? sm1 : in_data.mqy[SW-1:0];
      qmax_x = (in_data.mqx >= NW'(sm1)) ? sm1 : in_data.mqx[SW-1:0];

      s5_in.bad    = in_data.bad;
      s5_in.id     = in_data.id;
      s5_in.x0     = in_data.x == '0;
      s5_in.y0     = in_data.y == '0;
      s5_in.z0     = in_data.z == '0;
      s5_in.xin    = in_data.x < IDW'(cfg.s);
      s5_in.xle    = in_data.x <= IDW'(cfg.s);
      s5_in.fwd_x  = (NW'(in_data.x) + NW'(1) < NW'(cfg.s)) && (in_data.mqx != '0);
      s5_in.fwd_y  = ((SW + 1)'(in_data.y) + (SW + 1)'(1) < (SW + 1)'(cfg.s))
                     && (in_data.mqy != '0);
      s5_in.fwd_z  = ((SW + 1)'(in_data.z) + (SW + 1)'(1) < (SW + 1)'(cfg.s))
                     && (in_data.m != '0);
      s5_in.qpos_x = qmax_x != '0;
      s5_in.qpos_y = qmax_y != '0;
      s5_in.qpos_z = qmax_z != '0;
      s5_in.prod_x = PX_W'(qmax_x) * PX_W'(cfg.ss);
      s5_in.prod_y = SSW'(qmax_y) * SSW'(cfg.s);
      s5_in.prod_z = qmax_z;
      s5_in.ry     = in_data.ry;
      s5_in.z      = in_data.z;
   end

   // stage 6: candidate node numbers and which of them exist
   always_comb begin
      idw          = NW'(s5_ff.id);
      s6_in.bad    = s5_ff.bad;

      s6_in.cand[XM] = s5_ff.x0 ? idw + NW'(s5_ff.prod_x)
                     : (s5_ff.xle ? idw - NW'(cfg.ss) : NW'(s5_ff.ry));
      s6_in.keep[XM] = s5_ff.x0 ? s5_ff.qpos_x : 1'b1;

      s6_in.cand[YM] = s5_ff.y0 ? idw + NW'(s5_ff.prod_y) : idw - NW'(cfg.s);
      s6_in.keep[YM] = s5_ff.xin && (s5_ff.y0 ? s5_ff.qpos_y : 1'b1);

      s6_in.cand[ZM] = s5_ff.z0 ? idw + NW'(s5_ff.prod_z) : idw - NW'(1);
      s6_in.keep[ZM] = s5_ff.xin && (s5_ff.z0 ? s5_ff.qpos_z : 1'b1);

      s6_in.cand[XP] = s5_ff.fwd_x ? idw + NW'(cfg.ss) : NW'(s5_ff.ry);
      s6_in.keep[XP] = s5_ff.fwd_x || !s5_ff.x0;

      // fallback to y = 0 keeps x and z
      s6_in.cand[YP] = s5_ff.fwd_y ? idw + NW'(cfg.s)
                     : idw - NW'(s5_ff.ry) + NW'(s5_ff.z);
      s6_in.keep[YP] = s5_ff.xin && (s5_ff.fwd_y || !s5_ff.y0);

      s6_in.cand[ZP] = s5_ff.fwd_z ? idw + NW'(1) : idw - NW'(s5_ff.z);
      s6_in.keep[ZP] = s5_ff.xin && (s5_ff.fwd_z || !s5_ff.z0);
   end

   // stage 7: drop a candidate equal to any earlier existing one
   always_comb begin
      s7_in = s6_ff;
      for (int i = 1; i < NB; i++) begin
         for (int j = 0; j < i; j++) begin
            if (s6_ff.keep[j] && (s6_ff.cand[j] == s6_ff.cand[i])) begin
               s7_in.keep[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         if (s5_ready) s5_valid_ff <= in_valid;
         if (s6_ready) s6_valid_ff <= s5_valid_ff;
         if (s7_ready) s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready && in_valid) s5_ff <= s5_in;
      if (s6_ready && s5_valid_ff) s6_ff <= s6_in;
      if (s7_ready && s6_valid_ff) s7_ff <= s7_in;
   end

   assign out_valid = s7_valid_ff;
   assign out_data  = s7_ff;

endmodule

`default_nettype wire

/* src/t3n_emit.sv */
`timescale 1ns / 1ps
`default_nettype none

// turns one candidate set into result beats, lowest slot first
module t3n_emit (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire t3n_pkg::cand_type       in_data,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output logic [t3n_pkg::IDW-1:0]      out_neighbor_id,
   output logic [t3n_pkg::STW-1:0]      out_status,
   output logic                         out_last
);
   import t3n_pkg::*;

   logic                  valid_ff;
   logic [NB-1:0]         mask_ff;
   logic [NB-1:0][NW-1:0] cand_ff;
   logic [STW-1:0]        status_ff, status_in;
   logic [SELW-1:0]       sel;
   logic [NB-1:0]         mask_clr;
   logic                  last;
   logic                  beat;

   always_comb begin
      sel = '0;
      for (int i = NB - 1; i >= 0; i--) begin
         if (mask_ff[i]) sel = SELW'(i);
      end
      mask_clr      = mask_ff;
      mask_clr[sel] = 1'b0;
   end

   assign last     = (status_ff != ST_NEIGHBOR) || (mask_clr == '0);
   assign beat     = valid_ff && out_ready;
   assign in_ready = !valid_ff || (out_ready && last);

   always_comb begin
      if (in_data.bad) begin
         status_in = ST_BAD;
      end else if (in_data.keep == '0) begin
         status_in = ST_NONE;
      end else begin
         status_in = ST_NEIGHBOR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         if (in_valid) begin
            cand_ff   <= in_data.cand;
            status_ff <= status_in;
            mask_ff   <= (status_in == ST_NEIGHBOR) ? in_data.keep : '0;
         end
      end else if (beat) begin
         mask_ff <= mask_clr;
      end
   end

   assign out_valid       = valid_ff;
   assign out_status      = status_ff;
   assign out_last        = last;
   assign out_neighbor_id = (status_ff == ST_NEIGHBOR) ? cand_ff[sel][IDW-1:0] : '0;

endmodule

`default_nettype wire
